/* sv/tvrd_pkg.sv */
// Shared types, codes and the EBCDIC translation table of the tape record deframer.
`default_nettype none

package tvrd_pkg;

  localparam int unsigned CfgWidth = 16;
  localparam int unsigned CfgIdxWidth = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] REG_RECORD_MODE  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_ADD_NEWLINE  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_MAX_DATA_LEN = 2'd2;

  localparam logic [15:0] MAX_DATA_LEN_RESET = 16'd1023;

  // Record modes; the remaining codes pass bytes through unchanged.
  localparam logic [1:0] MODE_VAR = 2'd0;
  localparam logic [1:0] MODE_EBC = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_BYTE  = 3'd0;
  localparam logic [2:0] ST_DONE  = 3'd1;
  localparam logic [2:0] ST_BAD   = 3'd2;
  localparam logic [2:0] ST_UNEXP = 3'd3;
  localparam logic [2:0] ST_OVER  = 3'd4;

  // Phases of variable ASCII mode.
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_WS     = 3'd1;
  localparam logic [2:0] PH_DIG    = 3'd2;
  localparam logic [2:0] PH_FROZEN = 3'd3;
  localparam logic [2:0] PH_NEG    = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;

  // Phases of EBCDIC blocked mode.
  localparam logic [2:0] EB_IDLE = 3'd0;
  localparam logic [2:0] EB_BDW  = 3'd1;
  localparam logic [2:0] EB_RDW  = 3'd2;
  localparam logic [2:0] EB_DATA = 3'd3;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_FILL  = 8'h5E;

  typedef struct packed {
    logic [1:0]  record_mode;
    logic        add_newline;
    logic [15:0] max_data_len;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] count_value;
    logic [1:0]  digit_index;
    logic [15:0] record_left;
    logic [16:0] block_left;
    logic        halted;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } result_t;

  localparam logic [7:0] EbcToAsc [256] = '{
    8'o000, 8'o001, 8'o002, 8'o003, 8'o234, 8'o011, 8'o206, 8'o177,
    8'o227, 8'o215, 8'o216, 8'o013, 8'o014, 8'o015, 8'o016, 8'o017,
    8'o020, 8'o021, 8'o022, 8'o023, 8'o235, 8'o205, 8'o010, 8'o207,
    8'o030, 8'o031, 8'o222, 8'o217, 8'o034, 8'o035, 8'o036, 8'o037,
    8'o200, 8'o201, 8'o202, 8'o203, 8'o204, 8'o012, 8'o027, 8'o033,
    8'o210, 8'o211, 8'o212, 8'o213, 8'o214, 8'o005, 8'o006, 8'o007,
    8'o220, 8'o221, 8'o026, 8'o223, 8'o224, 8'o225, 8'o226, 8'o004,
    8'o230, 8'o231, 8'o232, 8'o233, 8'o024, 8'o025, 8'o236, 8'o032,
    8'o040, 8'o240, 8'o241, 8'o242, 8'o243, 8'o244, 8'o245, 8'o246,
    8'o247, 8'o250, 8'o133, 8'o056, 8'o074, 8'o050, 8'o053, 8'o041,
    8'o046, 8'o251, 8'o252, 8'o253, 8'o254, 8'o255, 8'o256, 8'o257,
    8'o260, 8'o261, 8'o135, 8'o044, 8'o052, 8'o051, 8'o073, 8'o136,
    8'o055, 8'o057, 8'o262, 8'o263, 8'o264, 8'o265, 8'o266, 8'o267,
    8'o270, 8'o271, 8'o174, 8'o054, 8'o045, 8'o137, 8'o076, 8'o077,
    8'o272, 8'o273, 8'o274, 8'o275, 8'o276, 8'o277, 8'o300, 8'o301,
    8'o302, 8'o140, 8'o072, 8'o043, 8'o100, 8'o047, 8'o075, 8'o042,
    8'o303, 8'o141, 8'o142, 8'o143, 8'o144, 8'o145, 8'o146, 8'o147,
    8'o150, 8'o151, 8'o304, 8'o305, 8'o306, 8'o307, 8'o310, 8'o311,
    8'o312, 8'o152, 8'o153, 8'o154, 8'o155, 8'o156, 8'o157, 8'o160,
    8'o161, 8'o162, 8'o313, 8'o314, 8'o315, 8'o316, 8'o317, 8'o320,
    8'o321, 8'o176, 8'o163, 8'o164, 8'o165, 8'o166, 8'o167, 8'o170,
    8'o171, 8'o172, 8'o322, 8'o323, 8'o324, 8'o325, 8'o326, 8'o327,
    8'o330, 8'o331, 8'o332, 8'o333, 8'o334, 8'o335, 8'o336, 8'o337,
    8'o340, 8'o341, 8'o342, 8'o343, 8'o344, 8'o345, 8'o346, 8'o347,
    8'o173, 8'o101, 8'o102, 8'o103, 8'o104, 8'o105, 8'o106, 8'o107,
    8'o110, 8'o111, 8'o350, 8'o351, 8'o352, 8'o353, 8'o354, 8'o355,
    8'o175, 8'o112, 8'o113, 8'o114, 8'o115, 8'o116, 8'o117, 8'o120,
    8'o121, 8'o122, 8'o356, 8'o357, 8'o360, 8'o361, 8'o362, 8'o363,
    8'o134, 8'o237, 8'o123, 8'o124, 8'o125, 8'o126, 8'o127, 8'o130,
    8'o131, 8'o132, 8'o364, 8'o365, 8'o366, 8'o367, 8'o370, 8'o371,
    8'o060, 8'o061, 8'o062, 8'o063, 8'o064, 8'o065, 8'o066, 8'o067,
    8'o070, 8'o071, 8'o372, 8'o373, 8'o374, 8'o375, 8'o376, 8'o377
  };

endpackage

`default_nettype wire

/* sv/tvrd_step.sv */
// Next-state and result logic of the deframer for one input item.
`default_nettype none

module tvrd_step (
  input  var tvrd_pkg::cfg_t    cfg_i,
  input  var tvrd_pkg::state_t  state_i,
  input  wire logic             req_type_i,
  input  wire logic [7:0]       data_byte_i,
  output tvrd_pkg::state_t      state_o,
  output tvrd_pkg::result_t     res0_o,
  output tvrd_pkg::result_t     res1_o,
  output logic [1:0]            num_res_o
);

  logic        is_digit;
  logic        is_space;
  logic [2:0]  ph_var;
  logic [2:0]  ph_ebc;
  logic [2:0]  a_ph_in;
  logic [15:0] a_cv_in;
  logic [2:0]  a_ph;
  logic [15:0] a_cv;
  logic [15:0] a_len;
  logic [15:0] rl_dec;
  logic [2:0]  e_ph;
  logic [1:0]  e_di;
  logic [15:0] e_cv;
  logic [16:0] e_bl_rem;

  assign is_digit = (data_byte_i >= tvrd_pkg::CHAR_ZERO) && (data_byte_i <= tvrd_pkg::CHAR_NINE);
  assign is_space = (data_byte_i == tvrd_pkg::CHAR_SPACE) ||
                    ((data_byte_i >= tvrd_pkg::CHAR_TAB) && (data_byte_i <= tvrd_pkg::CHAR_CR));

  assign ph_var = (state_i.phase > tvrd_pkg::PH_DATA) ? tvrd_pkg::PH_IDLE : state_i.phase;
  assign ph_ebc = (state_i.phase > tvrd_pkg::EB_DATA) ? tvrd_pkg::EB_IDLE : state_i.phase;
  assign rl_dec = (state_i.record_left != 16'd0) ? state_i.record_left - 16'd1 : 16'd0;

  // A new count starts the number scan in the white space phase with a cleared value.
  assign a_ph_in = (ph_var == tvrd_pkg::PH_IDLE) ? tvrd_pkg::PH_WS : ph_var;
  assign a_cv_in = (ph_var == tvrd_pkg::PH_IDLE) ? 16'd0 : state_i.count_value;

  always_comb begin
    a_ph = a_ph_in;
    a_cv = a_cv_in;
    if (a_ph_in == tvrd_pkg::PH_WS) begin
      if (is_space) begin
        a_ph = tvrd_pkg::PH_WS;
      end else if (data_byte_i == tvrd_pkg::CHAR_PLUS) begin
        a_ph = tvrd_pkg::PH_DIG;
      end else if (data_byte_i == tvrd_pkg::CHAR_MINUS) begin
        a_ph = tvrd_pkg::PH_NEG;
      end else if (is_digit) begin
        a_ph = tvrd_pkg::PH_DIG;
        a_cv = {12'd0, data_byte_i[3:0]};
      end else begin
        a_ph = tvrd_pkg::PH_FROZEN;
      end
    end else if (a_ph_in == tvrd_pkg::PH_DIG) begin
      if (is_digit) begin
        a_cv = {a_cv_in[12:0], 3'b000} + {a_cv_in[14:0], 1'b0} + {12'd0, data_byte_i[3:0]};
      end else begin
        a_ph = tvrd_pkg::PH_FROZEN;
      end
    end
  end

  assign a_len = a_cv - 16'd4;

  // Descriptor bytes: the first two carry the big-endian length.
  assign e_ph = (ph_ebc == tvrd_pkg::EB_IDLE) ? tvrd_pkg::EB_BDW : ph_ebc;
  assign e_di = (ph_ebc == tvrd_pkg::EB_IDLE) ? 2'd0 : state_i.digit_index;

  always_comb begin
    case (e_di)
      2'd0:    e_cv = {data_byte_i, 8'h00};
      2'd1:    e_cv = state_i.count_value | {8'h00, data_byte_i};
      default: e_cv = state_i.count_value;
    endcase
  end

  assign e_bl_rem = state_i.block_left - {1'b0, e_cv};

  always_comb begin
    state_o   = state_i;
    num_res_o = 2'd0;
    res0_o    = '0;
    res1_o    = '0;
    res1_o.out_byte = tvrd_pkg::CHAR_NL;
    res1_o.status   = tvrd_pkg::ST_BYTE;

    if (req_type_i) begin
      if (!state_i.halted && state_i.phase != 3'd0 &&
          (cfg_i.record_mode == tvrd_pkg::MODE_VAR ||
           cfg_i.record_mode == tvrd_pkg::MODE_EBC)) begin
        res0_o.status = tvrd_pkg::ST_UNEXP;
      end else begin
        res0_o.status = tvrd_pkg::ST_DONE;
      end
      state_o   = '0;
      num_res_o = 2'd1;
    end else if (state_i.halted) begin
      num_res_o = 2'd0;
    end else begin
      case (cfg_i.record_mode)
        tvrd_pkg::MODE_VAR: begin
          state_o.phase = ph_var;
          if (ph_var == tvrd_pkg::PH_IDLE) begin
            if (data_byte_i != tvrd_pkg::CHAR_FILL) begin
              state_o.phase       = a_ph;
              state_o.count_value = a_cv;
              state_o.digit_index = 2'd1;
            end
          end else if (ph_var == tvrd_pkg::PH_DATA) begin
            res0_o.out_byte     = data_byte_i;
            num_res_o           = 2'd1;
            state_o.record_left = rl_dec;
            if (rl_dec == 16'd0) begin
              state_o.phase = tvrd_pkg::PH_IDLE;
              if (cfg_i.add_newline) begin
                num_res_o = 2'd2;
              end
            end
          end else begin
            state_o.phase       = a_ph;
            state_o.count_value = a_cv;
            if (state_i.digit_index != 2'd3) begin
              state_o.digit_index = state_i.digit_index + 2'd1;
            end else begin
              state_o.digit_index = 2'd0;
              if (a_ph == tvrd_pkg::PH_NEG || a_cv < 16'd4 || a_len > cfg_i.max_data_len) begin
                state_o.halted      = 1'b1;
                state_o.phase       = tvrd_pkg::PH_IDLE;
                state_o.record_left = 16'd0;
                state_o.block_left  = 17'd0;
                res0_o.status       = tvrd_pkg::ST_BAD;
                num_res_o           = 2'd1;
              end else begin
                state_o.record_left = a_len;
                if (a_len == 16'd0) begin
                  // An empty record yields only its newline, and that only when add_newline is set.
                  state_o.phase = tvrd_pkg::PH_IDLE;
                  if (cfg_i.add_newline) begin
                    res0_o.out_byte = tvrd_pkg::CHAR_NL;
                    num_res_o       = 2'd1;
                  end
                end else begin
                  state_o.phase = tvrd_pkg::PH_DATA;
                end
              end
            end
          end
        end

        tvrd_pkg::MODE_EBC: begin
          if (ph_ebc == tvrd_pkg::EB_DATA) begin
            res0_o.out_byte     = tvrd_pkg::EbcToAsc[data_byte_i];
            num_res_o           = 2'd1;
            state_o.phase       = tvrd_pkg::EB_DATA;
            state_o.record_left = rl_dec;
            if (rl_dec == 16'd0) begin
              num_res_o     = 2'd2;
              state_o.phase = (state_i.block_left != 17'd0) ? tvrd_pkg::EB_RDW
                                                            : tvrd_pkg::EB_IDLE;
            end
          end else begin
            state_o.phase       = e_ph;
            state_o.count_value = e_cv;
            if (e_di != 2'd3) begin
              state_o.digit_index = e_di + 2'd1;
            end else begin
              state_o.digit_index = 2'd0;
              if (e_cv < 16'd4 ||
                  (e_ph != tvrd_pkg::EB_BDW && {1'b0, e_cv} > state_i.block_left)) begin
                state_o.halted      = 1'b1;
                state_o.phase       = tvrd_pkg::EB_IDLE;
                state_o.record_left = 16'd0;
                state_o.block_left  = 17'd0;
                res0_o.status       = (e_cv < 16'd4) ? tvrd_pkg::ST_BAD : tvrd_pkg::ST_OVER;
                num_res_o           = 2'd1;
              end else if (e_ph == tvrd_pkg::EB_BDW) begin
                state_o.block_left = {1'b0, e_cv - 16'd4};
                state_o.phase = (e_cv != 16'd4) ? tvrd_pkg::EB_RDW : tvrd_pkg::EB_IDLE;
              end else begin
                state_o.block_left  = e_bl_rem;
                state_o.record_left = e_cv - 16'd4;
                if (e_cv == 16'd4) begin
                  res0_o.out_byte = tvrd_pkg::CHAR_NL;
                  num_res_o       = 2'd1;
                  state_o.phase   = (e_bl_rem != 17'd0) ? tvrd_pkg::EB_RDW
                                                        : tvrd_pkg::EB_IDLE;
                end else begin
                  state_o.phase = tvrd_pkg::EB_DATA;
                end
              end
            end
          end
        end

        // Fixed mode and the spare mode code pass the byte through.
        default: begin
          res0_o.out_byte = data_byte_i;
          num_res_o       = 2'd1;
        end
      endcase
    end

    res0_o.last = (num_res_o == 2'd1);
    res1_o.last = 1'b1;
  end

endmodule

`default_nettype wire

/* sv/tape_variable_record_deframer.sv */
// Tape data section deframer: variable ASCII, fixed and EBCDIC blocked record modes.
//
// Takes one tape byte (or the end-of-section mark) per cycle, unless the
// output stalls, and emits record contents as a byte stream, with status
// items for section end and errors, through an input register and a two-entry
// output buffer that drains one result per cycle while the receiver is ready.
// An item that yields two results (a last record byte plus its newline) fills
// the buffer, so the next item that yields results waits until one has drained.
// Configuration may only be written while no item is in flight.
`default_nettype none

module tape_variable_record_deframer (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [tvrd_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  wire logic [tvrd_pkg::CfgWidth-1:0]      cfg_data_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [7:0]                         s_axis_tdata,  // [7:0] data_byte
  input  wire logic                               s_axis_tuser,  // [0] req_type
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [7:0]                              m_axis_tdata,  // [7:0] out_byte
  output logic [2:0]                              m_axis_tuser,  // [2:0] status
  output logic                                    m_axis_tlast
);

  tvrd_pkg::cfg_t    cfg_q;
  tvrd_pkg::state_t  st_q;
  tvrd_pkg::state_t  st_d;
  tvrd_pkg::result_t res0;
  tvrd_pkg::result_t res1;
  tvrd_pkg::result_t slot0_q;
  tvrd_pkg::result_t slot1_q;
  logic [1:0]        num_res;
  logic [1:0]        out_cnt_q;
  logic              in_valid_q;
  logic              in_req_q;
  logic [7:0]        in_byte_q;
  logic              pop;
  logic              consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.record_mode  <= tvrd_pkg::MODE_VAR;
      cfg_q.add_newline  <= 1'b0;
      cfg_q.max_data_len <= tvrd_pkg::MAX_DATA_LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tvrd_pkg::REG_RECORD_MODE:  cfg_q.record_mode  <= cfg_data_i[1:0];
        tvrd_pkg::REG_ADD_NEWLINE:  cfg_q.add_newline  <= cfg_data_i[0];
        tvrd_pkg::REG_MAX_DATA_LEN: cfg_q.max_data_len <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  tvrd_step u_step (
    .cfg_i       (cfg_q),
    .state_i     (st_q),
    .req_type_i  (in_req_q),
    .data_byte_i (in_byte_q),
    .state_o     (st_d),
    .res0_o      (res0),
    .res1_o      (res1),
    .num_res_o   (num_res)
  );

  assign pop = (out_cnt_q != 2'd0) && m_axis_tready;
  // An item leaves the input register once its results fit in the output buffer.
  assign consume = in_valid_q &&
                   ((num_res == 2'd0) || (out_cnt_q == 2'd0) ||
                    ((out_cnt_q == 2'd1) && m_axis_tready));
  assign s_axis_tready = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (consume) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= 2'd0;
    end else if (consume && num_res != 2'd0) begin
      out_cnt_q <= num_res;
    end else if (pop) begin
      out_cnt_q <= out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && num_res != 2'd0) begin
      slot0_q <= res0;
      slot1_q <= res1;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

  assign m_axis_tvalid = (out_cnt_q != 2'd0);
  assign m_axis_tdata  = slot0_q.out_byte;
  assign m_axis_tuser  = slot0_q.status;
  assign m_axis_tlast  = slot0_q.last;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_status_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != tvrd_pkg::ST_BYTE) |-> (m_axis_tdata == 8'd0))
    else $error("status item carries a nonzero byte");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != tvrd_pkg::ST_BYTE) |-> m_axis_tlast)
    else $error("status item is not the last result of its input");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && in_req_q) |=> (st_q.phase == tvrd_pkg::PH_IDLE && !st_q.halted))
    else $error("end mark did not clear the section state");
`endif

endmodule

`default_nettype wire
